/* design/rbsm_pkg.sv */
package rbsm_pkg;

   localparam int unsigned CRD_W  = 17;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned BIT_W  = 6;
   localparam int unsigned FLD_W  = 11;
   localparam int unsigned MODE_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_INVERT = 2'd2
   } mode_type;

   typedef struct packed {
      logic              valid;
      logic              active;
      logic [MODE_W-1:0] mode;
      logic [CRD_W-1:0]  lo0;
      logic [CRD_W-1:0]  hi0;
      logic              found;
      logic [CRD_W-1:0]  pos;
   } token_type;

   function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] w);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) begin
            r = BIT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

/* design/rbsm_req_if.sv */
interface rbsm_req_if
   import rbsm_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [FLD_W-1:0]  range_low;
   logic [FLD_W-1:0]  range_high;

   modport source (output valid, output mode, output range_low, output range_high,
                   input ready);
   modport sink   (input valid, input mode, input range_low, input range_high,
                   output ready);
endinterface

/* design/rbsm_rsp_if.sv */
interface rbsm_rsp_if
   import rbsm_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [FLD_W-1:0] mex;

   modport source (output valid, output mex, input ready);
   modport sink   (input valid, input mex, output ready);
endinterface

/* design/range_bitmap_set_mex_core.sv */
// Presence bitmap over positions 1..POSITIONS, one 64-bit word per cell in a chain
// of POSITIONS/64 cells, rounded up (16 at the default). A request enters cell 0
// and moves one cell per cycle while the chain advances; each cell applies add,
// remove or invert to its word and passes on the first free position found so far,
// and the mex of the last cell is registered in the output register. Requests
// stream into the chain at one per cycle while the response side keeps up; a
// stalled response freezes the whole chain. The bitmap is empty after reset.
module range_bitmap_set_mex_core
   import rbsm_pkg::*;
#(
   parameter int unsigned POSITIONS = 1024
) (
   input  logic       clock,
   input  logic       reset,
   rbsm_req_if.sink   req,
   rbsm_rsp_if.source rsp
);

   localparam int unsigned WORDS = (POSITIONS + WORD_W - 1) / WORD_W;
   localparam logic [CRD_W-1:0] LAST_POS = CRD_W'(POSITIONS);
   localparam logic [CRD_W-1:0] FULL_MEX = CRD_W'(POSITIONS + 1);

   token_type        tok [WORDS+1];
   token_type        tok_head;
   logic             advance;
   logic [CRD_W-1:0] lo_c;
   logic [CRD_W-1:0] hi_c;
   logic [CRD_W-1:0] pos1;
   logic             rsp_valid_ff;
   logic [FLD_W-1:0] mex_ff;
   logic [FLD_W-1:0] mex_in;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      lo_c = (req.range_low == '0) ? CRD_W'(1) : CRD_W'(req.range_low);
      hi_c = (CRD_W'(req.range_high) > LAST_POS) ? LAST_POS : CRD_W'(req.range_high);
      tok_head        = '0;
      tok_head.valid  = req.valid;
      tok_head.mode   = req.mode;
      tok_head.active = (req.mode == MODE_ADD || req.mode == MODE_REMOVE ||
                         req.mode == MODE_INVERT) && (lo_c <= hi_c);
      tok_head.lo0    = lo_c - CRD_W'(1);
      tok_head.hi0    = hi_c - CRD_W'(1);
   end

   assign tok[0] = tok_head;

   for (genvar g = 0; g < WORDS; g++) begin : g_cell
      rbsm_cell #(.IDX(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1])
      );
   end

   always_comb begin
      pos1 = tok[WORDS].pos + CRD_W'(1);
      if (tok[WORDS].found && pos1 <= LAST_POS) begin
         mex_in = pos1[FLD_W-1:0];
      end else begin
         mex_in = FULL_MEX[FLD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tok[WORDS].valid;
         mex_ff       <= mex_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.mex   = mex_ff;

`ifndef ASSERT_OFF
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response pending right after reset");

   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(tok[WORDS]))
      else $error("chain moved while the response was stalled");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      tok[WORDS].valid && tok[WORDS].found |-> tok[WORDS].pos < CRD_W'(WORDS * WORD_W))
      else $error("free position beyond the bitmap");
`endif

endmodule

/* design/rbsm_cell.sv */
module rbsm_cell
   import rbsm_pkg::*;
#(
   parameter int unsigned IDX = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  token_type tok_in,
   output token_type tok_out
);

   localparam logic [CRD_W-BIT_W-1:0] WIDX = (CRD_W-BIT_W)'(IDX);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;
   logic [WORD_W-1:0] low_mask;
   logic [WORD_W-1:0] high_mask;
   logic [WORD_W-1:0] mask;
   token_type         tok_ff;
   token_type         tok_in_next;

   always_comb begin
      if (tok_in.lo0[CRD_W-1:BIT_W] < WIDX) begin
         low_mask = '1;
      end else if (tok_in.lo0[CRD_W-1:BIT_W] == WIDX) begin
         low_mask = {WORD_W{1'b1}} << tok_in.lo0[BIT_W-1:0];
      end else begin
         low_mask = '0;
      end
      if (tok_in.hi0[CRD_W-1:BIT_W] > WIDX) begin
         high_mask = '1;
      end else if (tok_in.hi0[CRD_W-1:BIT_W] == WIDX) begin
         high_mask = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - tok_in.hi0[BIT_W-1:0]);
      end else begin
         high_mask = '0;
      end
      mask = low_mask & high_mask & {WORD_W{tok_in.valid & tok_in.active}};

      case (tok_in.mode)
         MODE_ADD:    word_in = word_ff | mask;
         MODE_REMOVE: word_in = word_ff & ~mask;
         MODE_INVERT: word_in = word_ff ^ mask;
         default:     word_in = word_ff;
      endcase

      tok_in_next = tok_in;
      if (!tok_in.found && (word_in != {WORD_W{1'b1}})) begin
         tok_in_next.found = 1'b1;
         tok_in_next.pos   = {WIDX, first_zero(word_in)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff      <= '0;
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in;
         tok_ff  <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

`ifndef ASSERT_OFF
   a_reset_clear: assert property (@(posedge clock)
      reset |=> word_ff == '0 && !tok_out.valid)
      else $error("bitmap word or token left over after reset");

   a_word_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(word_ff))
      else $error("bitmap word changed while the chain was stalled");

   a_found_kept: assert property (@(posedge clock) disable iff (reset)
      advance && tok_in.valid && tok_in.found |=> tok_out.found &&
         tok_out.pos == $past(tok_in.pos))
      else $error("earlier free position lost in the chain");
`endif

endmodule
